// File: hdl/fsacb_pkg.sv
// Shared types and constants of the flag-setting ALU with conditional branch.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fsacb_pkg;

    // Datapath and register file
    localparam int DATA_WIDTH = 64;
    localparam int PC_WIDTH   = 64;
    localparam int RESULT_W   = 64;
    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam logic [REG_IDX_W-1:0] ZERO_REG = REG_IDX_W'(REG_COUNT - 1);

    // Field widths
    localparam int IMM_W     = 12;
    localparam int IMM_EXT_W = 2 * IMM_W;
    localparam int SHAMT_W   = 6;
    localparam int OFFSET_W  = 19;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = RESULT_W + PC_WIDTH;
    localparam int M_TUSER_W = 4;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_ADDS_IMM   = 3'd0,
        MODE_SUBS_IMM   = 3'd1,
        MODE_ADDS_REG   = 3'd2,
        MODE_SUBS_REG   = 3'd3,
        MODE_ANDS_SHIFT = 3'd4,
        MODE_BCOND      = 3'd5
    } mode_t;

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;

    localparam logic [3:0] CC_EQ = 4'h0;
    localparam logic [3:0] CC_NE = 4'h1;
    localparam logic [3:0] CC_GE = 4'hA;
    localparam logic [3:0] CC_LT = 4'hB;
    localparam logic [3:0] CC_GT = 4'hC;
    localparam logic [3:0] CC_LE = 4'hD;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB,
        OP_AND_LSL,
        OP_AND_LSR,
        OP_BRANCH
    } op_t;

    typedef enum logic [2:0] {
        BR_NEVER,
        BR_EQ,
        BR_NE,
        BR_GT,
        BR_LT,
        BR_GE,
        BR_LE
    } br_cond_t;

    // One classified request as it travels through the queue
    typedef struct packed {
        op_t                        op;
        logic                       use_imm;
        logic [IMM_EXT_W-1:0]       imm;
        logic                       wr_en;
        logic [REG_IDX_W-1:0]       dest;
        logic [REG_IDX_W-1:0]       src_a;
        logic [REG_IDX_W-1:0]       src_b;
        logic [SHAMT_W-1:0]         shamt;
        br_cond_t                   cond;
        logic signed [OFFSET_W-1:0] offset;
    } item_t;

    // Queue status towards the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

// File: hdl/fsacb_front.sv
// Front end: unpacks an incoming request and classifies it into an item_t.
// Depends on fsacb_pkg.
`default_nettype none

module fsacb_front (
    input  wire logic [fsacb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [fsacb_pkg::S_TUSER_W-1:0] s_tuser,
    output fsacb_pkg::item_t                     item
);

    localparam int DEST_LO  = 0;
    localparam int FIRST_LO = DEST_LO + fsacb_pkg::REG_IDX_W;
    localparam int SECOND_LO = FIRST_LO + fsacb_pkg::REG_IDX_W;
    localparam int IMM_LO   = SECOND_LO + fsacb_pkg::REG_IDX_W;
    localparam int SH12_LO  = IMM_LO + fsacb_pkg::IMM_W;
    localparam int KIND_LO  = SH12_LO + 1;
    localparam int AMT_LO   = KIND_LO + 2;
    localparam int CC_LO    = AMT_LO + fsacb_pkg::SHAMT_W;
    localparam int OFF_LO   = CC_LO + 4;

    fsacb_pkg::mode_t                   mode;
    logic [fsacb_pkg::REG_IDX_W-1:0]    dest;
    logic [fsacb_pkg::IMM_W-1:0]        imm12;
    logic                               imm_shift12;
    logic [1:0]                         shift_kind;
    logic [3:0]                         cond_code;
    logic                               is_alu;

    assign mode        = fsacb_pkg::mode_t'(s_tuser);
    assign dest        = s_tdata[DEST_LO +: fsacb_pkg::REG_IDX_W];
    assign imm12       = s_tdata[IMM_LO +: fsacb_pkg::IMM_W];
    assign imm_shift12 = s_tdata[SH12_LO];
    assign shift_kind  = s_tdata[KIND_LO +: 2];
    assign cond_code   = s_tdata[CC_LO +: 4];

    always_comb begin
        item         = '0;
        item.op      = fsacb_pkg::OP_NOP;
        item.cond    = fsacb_pkg::BR_NEVER;
        item.dest    = dest;
        item.src_a   = s_tdata[FIRST_LO +: fsacb_pkg::REG_IDX_W];
        item.src_b   = s_tdata[SECOND_LO +: fsacb_pkg::REG_IDX_W];
        item.shamt   = s_tdata[AMT_LO +: fsacb_pkg::SHAMT_W];
        item.offset  = s_tdata[OFF_LO +: fsacb_pkg::OFFSET_W];
        item.imm     = imm_shift12 ? {imm12, fsacb_pkg::IMM_W'(0)}
                                   : {fsacb_pkg::IMM_W'(0), imm12};
        is_alu       = 1'b0;

        case (mode)
            fsacb_pkg::MODE_ADDS_IMM: begin
                item.op      = fsacb_pkg::OP_ADD;
                item.use_imm = 1'b1;
                is_alu       = 1'b1;
            end
            fsacb_pkg::MODE_SUBS_IMM: begin
                item.op      = fsacb_pkg::OP_SUB;
                item.use_imm = 1'b1;
                is_alu       = 1'b1;
            end
            fsacb_pkg::MODE_ADDS_REG: begin
                item.op = fsacb_pkg::OP_ADD;
                is_alu  = 1'b1;
            end
            fsacb_pkg::MODE_SUBS_REG: begin
                item.op = fsacb_pkg::OP_SUB;
                is_alu  = 1'b1;
            end
            fsacb_pkg::MODE_ANDS_SHIFT: begin
                case (shift_kind)
                    fsacb_pkg::SHIFT_LSL: begin
                        item.op = fsacb_pkg::OP_AND_LSL;
                        is_alu  = 1'b1;
                    end
                    fsacb_pkg::SHIFT_LSR: begin
                        item.op = fsacb_pkg::OP_AND_LSR;
                        is_alu  = 1'b1;
                    end
                    default: begin
                        item.op = fsacb_pkg::OP_NOP;
                    end
                endcase
            end
            fsacb_pkg::MODE_BCOND: begin
                item.op = fsacb_pkg::OP_BRANCH;
                case (cond_code)
                    fsacb_pkg::CC_EQ: item.cond = fsacb_pkg::BR_EQ;
                    fsacb_pkg::CC_NE: item.cond = fsacb_pkg::BR_NE;
                    fsacb_pkg::CC_GT: item.cond = fsacb_pkg::BR_GT;
                    fsacb_pkg::CC_LT: item.cond = fsacb_pkg::BR_LT;
                    fsacb_pkg::CC_GE: item.cond = fsacb_pkg::BR_GE;
                    fsacb_pkg::CC_LE: item.cond = fsacb_pkg::BR_LE;
                    default:          item.cond = fsacb_pkg::BR_NEVER;
                endcase
            end
            default: begin
                item.op = fsacb_pkg::OP_NOP;
            end
        endcase

        // the zero register is never a write target, flags still update
        item.wr_en = is_alu && (dest != fsacb_pkg::ZERO_REG);
    end

endmodule

`default_nettype wire

// File: hdl/fsacb_queue.sv
// Short request queue that decouples the front end from the back end.
// Depends on fsacb_pkg.
`default_nettype none

module fsacb_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  fsacb_pkg::item_t       push_item,
    input  wire logic              pop,
    output fsacb_pkg::item_t       head_item,
    output fsacb_pkg::q_status_t   status
);

    fsacb_pkg::item_t                entry_reg [fsacb_pkg::QUEUE_DEPTH];
    logic [fsacb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fsacb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fsacb_pkg::QCNT_W-1:0]    count_reg;
    logic [fsacb_pkg::QCNT_W-1:0]    count_next;

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + fsacb_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - fsacb_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + fsacb_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + fsacb_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == fsacb_pkg::QCNT_W'(fsacb_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: hdl/fsacb_back.sv
// Back end: register file, execute stage, flags, PC and result register.
// Depends on fsacb_pkg.
`default_nettype none

module fsacb_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  fsacb_pkg::item_t                     head_item,
    input  fsacb_pkg::q_status_t                 q_status,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fsacb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [fsacb_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int DW = fsacb_pkg::DATA_WIDTH;

    // register file and its read side
    logic [DW-1:0]                      rf_mem [fsacb_pkg::REG_COUNT];
    logic [fsacb_pkg::REG_COUNT-1:0]    vld_reg;
    logic [DW-1:0]                      rd_a_reg;
    logic [DW-1:0]                      rd_b_reg;
    logic                               vld_a_reg;
    logic                               vld_b_reg;
    logic                               byp_a_reg;
    logic                               byp_b_reg;
    logic [DW-1:0]                      byp_data_reg;

    // execute stage
    fsacb_pkg::item_t                   x_item_reg;
    logic                               x_valid_reg;
    logic                               x_fire;
    logic                               x_load;
    logic [DW-1:0]                      op_a;
    logic [DW-1:0]                      op_b;
    logic [DW-1:0]                      op_2;
    logic [DW-1:0]                      alu_res;
    logic                               set_flags;
    logic                               cond_ok;
    logic                               taken;
    logic                               wr_en;

    // architectural flags and PC
    logic                               neg_reg;
    logic                               zero_reg;
    logic                               neg_next;
    logic                               zero_next;
    logic [fsacb_pkg::PC_WIDTH-1:0]     pc_reg;
    logic [fsacb_pkg::PC_WIDTH-1:0]     pc_next;

    // result register
    logic                               out_valid_reg;
    logic [fsacb_pkg::RESULT_W-1:0]     out_result_reg;
    logic [fsacb_pkg::PC_WIDTH-1:0]     out_pc_reg;
    logic                               out_written_reg;
    logic                               out_neg_reg;
    logic                               out_zero_reg;
    logic                               out_taken_reg;

    assign x_fire = x_valid_reg && (!out_valid_reg || m_tready);
    assign x_load = !x_valid_reg || x_fire;
    assign pop    = !q_status.empty && x_load;
    assign wr_en  = x_fire && x_item_reg.wr_en;

    // operands: bypass the write landing on the same edge as the read
    assign op_a = byp_a_reg ? byp_data_reg : (vld_a_reg ? rd_a_reg : '0);
    assign op_b = byp_b_reg ? byp_data_reg : (vld_b_reg ? rd_b_reg : '0);
    assign op_2 = x_item_reg.use_imm ? DW'(x_item_reg.imm) : op_b;

    always_comb begin
        alu_res   = '0;
        set_flags = 1'b0;
        case (x_item_reg.op)
            fsacb_pkg::OP_ADD: begin
                alu_res   = op_a + op_2;
                set_flags = 1'b1;
            end
            fsacb_pkg::OP_SUB: begin
                alu_res   = op_a - op_2;
                set_flags = 1'b1;
            end
            fsacb_pkg::OP_AND_LSL: begin
                alu_res   = op_a & (op_b << x_item_reg.shamt);
                set_flags = 1'b1;
            end
            fsacb_pkg::OP_AND_LSR: begin
                alu_res   = op_a & (op_b >> x_item_reg.shamt);
                set_flags = 1'b1;
            end
            default: begin
                alu_res   = '0;
                set_flags = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (x_item_reg.cond)
            fsacb_pkg::BR_EQ: cond_ok = zero_reg;
            fsacb_pkg::BR_NE: cond_ok = !zero_reg;
            fsacb_pkg::BR_GT: cond_ok = !neg_reg && !zero_reg;
            fsacb_pkg::BR_LT: cond_ok = neg_reg && !zero_reg;
            fsacb_pkg::BR_GE: cond_ok = !neg_reg;
            fsacb_pkg::BR_LE: cond_ok = neg_reg || zero_reg;
            default:          cond_ok = 1'b0;
        endcase
    end

    assign taken     = (x_item_reg.op == fsacb_pkg::OP_BRANCH) && cond_ok;
    assign neg_next  = set_flags ? alu_res[DW-1] : neg_reg;
    assign zero_next = set_flags ? (alu_res == '0) : zero_reg;
    assign pc_next   = taken
                     ? pc_reg + fsacb_pkg::PC_WIDTH'($signed({x_item_reg.offset, 2'b00}))
                     : pc_reg + fsacb_pkg::PC_WIDTH'(4);

    // register file storage, read data registered at pop
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[x_item_reg.dest] <= alu_res;
        end
        if (pop) begin
            rd_a_reg <= rf_mem[head_item.src_a];
            rd_b_reg <= rf_mem[head_item.src_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            x_item_reg <= head_item;
            vld_a_reg  <= vld_reg[head_item.src_a];
            vld_b_reg  <= vld_reg[head_item.src_b];
            byp_a_reg  <= wr_en && (x_item_reg.dest == head_item.src_a);
            byp_b_reg  <= wr_en && (x_item_reg.dest == head_item.src_b);
        end
        if (wr_en) begin
            byp_data_reg <= alu_res;
        end
        if (x_fire) begin
            out_result_reg  <= fsacb_pkg::RESULT_W'(alu_res);
            out_pc_reg      <= pc_next;
            out_written_reg <= x_item_reg.wr_en;
            out_neg_reg     <= neg_next;
            out_zero_reg    <= zero_next;
            out_taken_reg   <= taken;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            pc_reg        <= '0;
        end else begin
            if (wr_en) begin
                vld_reg[x_item_reg.dest] <= 1'b1;
            end
            if (x_load) begin
                x_valid_reg <= pop;
            end
            if (x_fire) begin
                out_valid_reg <= 1'b1;
                neg_reg       <= neg_next;
                zero_reg      <= zero_next;
                pc_reg        <= pc_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pc_reg, out_result_reg};
    assign m_tuser  = {out_taken_reg, out_zero_reg, out_neg_reg, out_written_reg};

endmodule

`default_nettype wire

// File: hdl/flag_setting_alu_with_cond_branch.sv
// Top level of the flag-setting ALU with conditional branch.
// Depends on fsacb_pkg, fsacb_front, fsacb_queue and fsacb_back.
//
//  Channel | Direction | tdata (low bit first)                    | tuser
//  --------+-----------+------------------------------------------+--------------------------
//  s_      | in        | dest, first, second, imm12, imm_shift12, | mode
//          |           | shift_kind, shift_amount, cond, offset   |
//  m_      | out       | result_value, next_pc                    | written, neg, zero, taken
//
// One request per cycle is sustained while m_tready is high; the execute stage
// reads the two source registers, updates flags and PC and fills the result register.
// A result appears on m_tvalid after its request has passed the queue and execute stage.
// Reset is synchronous; register-file valid bits clear at once, so there is
// no clearing pass.
// Stalls on m_tready hold the result register, then the execute stage, then
// fill the two-entry queue, after which s_tready drops.
`default_nettype none

module flag_setting_alu_with_cond_branch (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // dest_reg, first_reg, second_reg, imm12, imm_shift12, shift_kind,
    // shift_amount, cond_code, branch_offset, zero pad
    input  wire logic [fsacb_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  wire logic [fsacb_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // result_value, next_pc
    output logic [fsacb_pkg::M_TDATA_W-1:0]      m_tdata,
    // reg_written, neg_out, zero_out, branch_taken
    output logic [fsacb_pkg::M_TUSER_W-1:0]      m_tuser
);

    fsacb_pkg::item_t      front_item;
    fsacb_pkg::item_t      head_item;
    fsacb_pkg::q_status_t  q_status;
    logic                  push;
    logic                  pop;

    // take a request whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // classify the request
    fsacb_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    // hold classified requests until the back end takes them
    fsacb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    // execute against the register file, flags and PC
    fsacb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/fsacb_checker.sv
// Port-level checks for the flag-setting ALU, bound to the top level.
// Depends on fsacb_pkg and flag_setting_alu_with_cond_branch.
`default_nettype none

module fsacb_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [fsacb_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [fsacb_pkg::M_TUSER_W-1:0] m_tuser
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a taken branch writes nothing and reports a zero result
    a_branch_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> !m_tuser[0] && (m_tdata[63:0] == '0))
        else $error("taken branch wrote a result");

    // a written result sets the flags from its own value
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tuser[2] == (m_tdata[63:0] == '0)) &&
            (m_tuser[1] == m_tdata[fsacb_pkg::DATA_WIDTH-1]))
        else $error("flags disagree with written result");

endmodule

bind flag_setting_alu_with_cond_branch fsacb_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
